>>> design/pms_pkg.sv
// pms_pkg: shared types and codes for the partitioned member set unit
// no dependencies; used by controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

   // request kinds, all four codes are meaningful
   typedef enum logic [1:0] {
      KIND_ADD          = 2'd0,
      KIND_REMOVE_ID    = 2'd1,
      KIND_REMOVE_INDEX = 2'd2,
      KIND_READ         = 2'd3
   } kind_type;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FULL       = 3'd1;
   localparam logic [2:0] ST_DUP        = 3'd2;
   localparam logic [2:0] ST_EMPTY      = 3'd3;
   localparam logic [2:0] ST_NOT_MEMBER = 3'd4;
   localparam logic [2:0] ST_RANGE      = 3'd5;
   localparam logic [2:0] ST_UNKNOWN    = 3'd6;

   // field widths
   localparam int ID_W    = 6;
   localparam int COUNT_W = 7;

   // controller states
   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_CHECK = 5'b00100,
      S_SWAP1 = 5'b01000,
      S_SWAP2 = 5'b10000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic check;
      logic swap1;
      logic swap2;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic early_done;
      logic late_done;
   } stat_type;

endpackage

`default_nettype wire

>>> design/pms_ram.sv
// pms_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pms_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/pms_ctrl.sv
// pms_ctrl: controller state machine of the partitioned member set unit
// depends on pms_pkg
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire pms_pkg::stat_type  stat,
   output pms_pkg::cmd_type        cmd
);

   pms_pkg::state_type state_ff;
   pms_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pms_pkg::S_CLEAR: begin
            if (stat.clear_done) state_in = pms_pkg::S_IDLE;
         end
         pms_pkg::S_IDLE: begin
            if (start) state_in = pms_pkg::S_CHECK;
         end
         pms_pkg::S_CHECK: begin
            state_in = stat.early_done ? pms_pkg::S_IDLE : pms_pkg::S_SWAP1;
         end
         pms_pkg::S_SWAP1: begin
            state_in = stat.late_done ? pms_pkg::S_IDLE : pms_pkg::S_SWAP2;
         end
         pms_pkg::S_SWAP2: begin
            state_in = pms_pkg::S_IDLE;
         end
         default: begin
            state_in = pms_pkg::S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pms_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.clear_step = (state_ff == pms_pkg::S_CLEAR);
      cmd.capture    = (state_ff == pms_pkg::S_IDLE) && start;
      cmd.check      = (state_ff == pms_pkg::S_CHECK);
      cmd.swap1      = (state_ff == pms_pkg::S_SWAP1);
      cmd.swap2      = (state_ff == pms_pkg::S_SWAP2);
   end

   assign busy = (state_ff != pms_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> design/pms_datapath.sv
// pms_datapath: order and slot tables, member count and result registers
// depends on pms_pkg and pms_ram
`timescale 1ns / 1ps
`default_nettype none

module pms_datapath #(
   parameter int UNIVERSE_SIZE = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pms_pkg::cmd_type               cmd,
   output pms_pkg::stat_type                   stat,
   input  wire logic [1:0]                     req_kind,
   input  wire logic [pms_pkg::ID_W-1:0]       req_item_id,
   input  wire logic [pms_pkg::ID_W-1:0]       req_position,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [pms_pkg::ID_W-1:0]            rsp_item_out,
   output logic [pms_pkg::COUNT_W-1:0]         rsp_member_count
);

   localparam int IW = $clog2(UNIVERSE_SIZE);
   localparam logic [pms_pkg::COUNT_W-1:0] USIZE = pms_pkg::COUNT_W'(UNIVERSE_SIZE);
   localparam logic [IW-1:0] CLR_LAST = IW'(UNIVERSE_SIZE - 1);

   // captured request
   pms_pkg::kind_type              kind_ff;
   logic [pms_pkg::ID_W-1:0]       id_ff;
   logic [pms_pkg::ID_W-1:0]       pos_ff;

   // swap operands
   logic [IW-1:0] t_ff;
   logic [IW-1:0] a_ff;
   logic [IW-1:0] t_in;
   logic [IW-1:0] p_val;
   logic [IW-1:0] a_val;

   // control state
   logic [pms_pkg::COUNT_W-1:0] members_ff;
   logic [pms_pkg::COUNT_W-1:0] members_in;
   logic [pms_pkg::COUNT_W-1:0] members_m1;
   logic [IW-1:0]               clr_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;

   // result payload
   logic [2:0]               status_ff;
   logic [2:0]               status_in;
   logic [pms_pkg::ID_W-1:0] item_ff;
   logic [pms_pkg::ID_W-1:0] item_in;

   // table ports
   logic          ord_wr_en;
   logic [IW-1:0] ord_wr_addr;
   logic [IW-1:0] ord_wr_data;
   logic [IW-1:0] ord_pos_q;
   logic [IW-1:0] ord_t_q;
   logic          slot_wr_en;
   logic [IW-1:0] slot_wr_addr;
   logic [IW-1:0] slot_wr_data;
   logic [IW-1:0] slot_q;

   // checks
   logic       id_known;
   logic       early_err;
   logic [2:0] early_status;
   logic       late_err;
   logic [2:0] late_status;
   logic       is_read;

   // order table, position to id; two copies give two read addresses
   pms_ram #(.WIDTH(IW), .DEPTH(UNIVERSE_SIZE)) u_order_pos (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_addr (pos_ff[IW-1:0]),
      .rd_data (ord_pos_q)
   );

   pms_ram #(.WIDTH(IW), .DEPTH(UNIVERSE_SIZE)) u_order_last (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_addr (t_in),
      .rd_data (ord_t_q)
   );

   // slot table, id to position
   pms_ram #(.WIDTH(IW), .DEPTH(UNIVERSE_SIZE)) u_slot (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (id_ff[IW-1:0]),
      .rd_data (slot_q)
   );

   // partner slot: first free slot for add, last member for removes
   assign members_m1 = members_ff - pms_pkg::COUNT_W'(1);
   assign t_in = (kind_ff == pms_pkg::KIND_ADD) ? members_ff[IW-1:0] : members_m1[IW-1:0];

   assign id_known = ({1'b0, id_ff} < USIZE);
   assign is_read  = (kind_ff == pms_pkg::KIND_READ);

   // checks on count and fields, before any table read
   always_comb begin
      early_err    = 1'b0;
      early_status = pms_pkg::ST_OK;
      unique case (kind_ff)
         pms_pkg::KIND_ADD: begin
            if (members_ff >= USIZE) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_FULL;
            end else if (!id_known) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_UNKNOWN;
            end
         end
         pms_pkg::KIND_REMOVE_ID: begin
            if (members_ff == '0) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_EMPTY;
            end else if (!id_known) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_NOT_MEMBER;
            end
         end
         pms_pkg::KIND_REMOVE_INDEX: begin
            if (members_ff == '0) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_EMPTY;
            end else if ({1'b0, pos_ff} >= members_ff) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_RANGE;
            end
         end
         pms_pkg::KIND_READ: begin
            if ({1'b0, pos_ff} >= members_ff) begin
               early_err    = 1'b1;
               early_status = pms_pkg::ST_RANGE;
            end
         end
         default: begin
            early_err    = 1'b0;
            early_status = pms_pkg::ST_OK;
         end
      endcase
   end

   // target slot and id once the tables have been read
   assign p_val = (kind_ff == pms_pkg::KIND_REMOVE_INDEX) ? pos_ff[IW-1:0] : slot_q;
   assign a_val = (kind_ff == pms_pkg::KIND_REMOVE_INDEX) ? ord_pos_q : id_ff[IW-1:0];

   // membership checks on the looked-up slot
   always_comb begin
      late_err    = 1'b0;
      late_status = pms_pkg::ST_OK;
      if (kind_ff == pms_pkg::KIND_ADD && pms_pkg::COUNT_W'(p_val) < members_ff) begin
         late_err    = 1'b1;
         late_status = pms_pkg::ST_DUP;
      end else if (kind_ff == pms_pkg::KIND_REMOVE_ID &&
                   pms_pkg::COUNT_W'(p_val) >= members_ff) begin
         late_err    = 1'b1;
         late_status = pms_pkg::ST_NOT_MEMBER;
      end
   end

   // table writes: identity fill, then the two halves of the swap
   always_comb begin
      ord_wr_en    = 1'b0;
      ord_wr_addr  = clr_ff;
      ord_wr_data  = clr_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = clr_ff;
      slot_wr_data = clr_ff;
      priority if (cmd.clear_step) begin
         ord_wr_en  = 1'b1;
         slot_wr_en = 1'b1;
      end else if (cmd.swap1 && !late_err && !is_read) begin
         ord_wr_en    = 1'b1;
         ord_wr_addr  = p_val;
         ord_wr_data  = ord_t_q;
         slot_wr_en   = 1'b1;
         slot_wr_addr = ord_t_q;
         slot_wr_data = p_val;
      end else if (cmd.swap2) begin
         ord_wr_en    = 1'b1;
         ord_wr_addr  = t_ff;
         ord_wr_data  = a_ff;
         slot_wr_en   = 1'b1;
         slot_wr_addr = a_ff;
         slot_wr_data = t_ff;
      end else begin
         ord_wr_en  = 1'b0;
         slot_wr_en = 1'b0;
      end
   end

   // result and member count
   always_comb begin
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      item_in      = item_ff;
      members_in   = members_ff;
      priority if (cmd.check && early_err) begin
         rsp_valid_in = 1'b1;
         status_in    = early_status;
         item_in      = '0;
      end else if (cmd.swap1 && late_err) begin
         rsp_valid_in = 1'b1;
         status_in    = late_status;
         item_in      = '0;
      end else if (cmd.swap1 && is_read) begin
         rsp_valid_in = 1'b1;
         status_in    = pms_pkg::ST_OK;
         item_in      = pms_pkg::ID_W'(ord_pos_q);
      end else if (cmd.swap2) begin
         rsp_valid_in = 1'b1;
         status_in    = pms_pkg::ST_OK;
         item_in      = '0;
         members_in   = (kind_ff == pms_pkg::KIND_ADD) ?
                        members_ff + pms_pkg::COUNT_W'(1) : members_m1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         members_ff   <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         members_ff   <= members_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + IW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      item_ff   <= item_in;
      if (cmd.capture) begin
         kind_ff <= pms_pkg::kind_type'(req_kind);
         id_ff   <= req_item_id;
         pos_ff  <= req_position;
      end
      if (cmd.check) begin
         t_ff <= t_in;
      end
      if (cmd.swap1) begin
         a_ff <= a_val;
      end
   end

   assign stat.clear_done = (clr_ff == CLR_LAST);
   assign stat.early_done = early_err;
   assign stat.late_done  = late_err || is_read;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_item_out     = item_ff;
   assign rsp_member_count = members_ff;

endmodule

`default_nettype wire

>>> design/partitioned_member_set_unit.sv
// partitioned_member_set_unit: top level, a set kept as a swap-partitioned permutation
// Result strobe, registered: count or field errors come from the check state, reads,
// duplicate and non-member results from the first swap state, add and remove from the
// second; one request in flight at a time. Throughput is set by the two-step swap over
// single-write-port tables. After reset a clearing pass loads the identity permutation
// while busy is high. The result strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module partitioned_member_set_unit #(
   parameter int UNIVERSE_SIZE = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_kind,
   input  wire logic [pms_pkg::ID_W-1:0]      req_item_id,
   input  wire logic [pms_pkg::ID_W-1:0]      req_position,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [pms_pkg::ID_W-1:0]           rsp_item_out,
   output logic [pms_pkg::COUNT_W-1:0]        rsp_member_count
);

   pms_pkg::cmd_type  cmd;
   pms_pkg::stat_type stat;

   // sequencing
   pms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // tables and result registers
   pms_datapath #(.UNIVERSE_SIZE(UNIVERSE_SIZE)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_item_id      (req_item_id),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_item_out     (rsp_item_out),
      .rsp_member_count (rsp_member_count)
   );

endmodule

`default_nettype wire
